[design/rad_pkg.sv]
// Shared constants, codes and types of the AVI container parser.
package rad_pkg;

  localparam int unsigned MAX_NEST = 3;
  localparam int unsigned NEST_W   = $clog2(MAX_NEST + 1);
  localparam int unsigned IDX_W    = $clog2(MAX_NEST);
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned TDATA_W  = 200;

  localparam logic [31:0] FCC_RIFF = 32'h4646_4952;
  localparam logic [31:0] FCC_AVI  = 32'h2049_5641;
  localparam logic [31:0] FCC_LIST = 32'h5453_494C;
  localparam logic [31:0] FCC_HDRL = 32'h6C72_6468;
  localparam logic [31:0] FCC_MOVI = 32'h6976_6F6D;
  localparam logic [31:0] FCC_STRL = 32'h6C72_7473;
  localparam logic [31:0] FCC_AVIH = 32'h6869_7661;
  localparam logic [31:0] FCC_STRH = 32'h6872_7473;
  localparam logic [31:0] FCC_STRF = 32'h6672_7473;
  localparam logic [31:0] FCC_00DC = 32'h6364_3030;
  localparam logic [31:0] FCC_00DB = 32'h6264_3030;
  localparam logic [31:0] FCC_MJPG = 32'h4750_4A4D;
  localparam logic [31:0] USEC_PER_S = 32'd1000000;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NOT_AVI   = 3'd0;
  localparam logic [2:0] ERR_NO_MOVI   = 3'd1;
  localparam logic [2:0] ERR_BAD_FMT   = 3'd2;
  localparam logic [2:0] ERR_MALFORMED = 3'd3;
  localparam logic [2:0] ERR_NO_FRAMES = 3'd4;
  localparam logic [2:0] ERR_NO_SIZE   = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] rate;
    logic [31:0] total;
    logic [2:0]  err;
  } rad_res_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
  } rad_beat_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } rad_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } rad_div_rsp_t;

endpackage

[design/rad_front.sv]
// Input side: takes byte beats into a short queue for the parser.
module rad_front import rad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] in_data_i,
  output rad_beat_t head_o,
  input  logic      pop_i
);

  logic [7:0]        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign in_ready_o   = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[design/rad_div.sv]
// Restoring divider, one quotient bit per cycle.
module rad_div import rad_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rad_div_req_t req_i,
  output rad_div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] sh, diff;

  assign sh   = {rem_q, quo_q[31]};
  assign diff = sh - {1'b0, dvs_q};

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

[design/rad_back.sv]
// Parser core: chunk walk, header fields, frame entries and the result register.
module rad_back import rad_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [31:0]  total_len_i,
  input  rad_beat_t    head_i,
  output logic         pop_o,
  output rad_div_req_t div_req_o,
  input  rad_div_rsp_t div_rsp_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output rad_res_t     out_o
);

  typedef enum logic [2:0] {
    M_SIG, M_HDR, M_LTYPE, M_BODY, M_SKIP, M_IDLE, M_HALT
  } mode_e;

  typedef struct packed {
    logic [33:0]       tgt;
    logic [NEST_W-1:0] lvl;
  } goto_t;

  mode_e                     mode_q, mode_d;
  logic [31:0]               pos_q, pos_d;
  logic [63:0]               hs_q, hs_d;
  logic [MAX_NEST-1:0][33:0] end_q, end_d;
  logic [MAX_NEST-1:0]       pad_q, pad_d, movi_q, movi_d;
  logic [NEST_W-1:0]         lvl_q, lvl_d;
  logic [31:0]               fc_q, fc_d, sw_q, sw_d, sh_q, sh_d, sr_q, sr_d, ff_q, ff_d;
  logic                      mseen_q, mseen_d;
  logic [31:0]               id_q, id_d, size_q, size_d;
  logic [33:0]               ds_q, ds_d, hst_q, hst_d, skip_q, skip_d;
  logic                      div_have_q;
  logic [31:0]               div_quo_q;
  logic                      outv_q;
  rad_res_t                  res_q, res_d;
  logic                      emit;
  logic                      div_need;
  logic [31:0]               div_a, div_b, rate_q1;
  logic                      stall, go;

  function automatic goto_t go_to(logic [33:0] nxt, logic [NEST_W-1:0] lvl,
                                  logic [MAX_NEST-1:0][33:0] ends,
                                  logic [MAX_NEST-1:0] pads);
    goto_t             r;
    logic [NEST_W-1:0] idx;
    r.tgt = nxt;
    r.lvl = lvl;
    for (int k = 0; k < MAX_NEST; k++) begin
      idx = r.lvl - 1'b1;
      if (r.lvl != '0 &&
          ({1'b0, r.tgt} + 35'd8 > {1'b0, ends[idx[IDX_W-1:0]]})) begin
        r.tgt = ends[idx[IDX_W-1:0]] + {33'd0, pads[idx[IDX_W-1:0]]};
        r.lvl = r.lvl - 1'b1;
      end
    end
    return r;
  endfunction

  logic [63:0] hs;
  logic [31:0] hi;
  logic [33:0] p34, off, endc, padded;
  logic [NEST_W-1:0] li;

  assign hs      = {head_i.data, hs_q[63:8]};
  assign hi      = hs[63:32];
  assign p34     = {2'b00, pos_q};
  assign off     = p34 - ds_q;
  assign rate_q1 = (div_quo_q == '0) ? 32'd1 : div_quo_q;

  always_comb begin
    div_need = 1'b0;
    div_a    = USEC_PER_S;
    div_b    = hi;
    if (mode_q == M_BODY && p34 >= ds_q) begin
      if (id_q == FCC_AVIH && off == 34'd3 && hi != '0) begin
        div_need = 1'b1;
      end else if (id_q == FCC_STRH && off == 34'd27 && fc_q != '0 && hi != '0) begin
        div_need = 1'b1;
        div_a    = hi;
        div_b    = fc_q;
      end
    end
  end

  assign stall = (outv_q && !out_ready_i && emit) || (div_need && !div_have_q);
  assign go    = head_i.valid && !stall;
  assign pop_o = go;

  assign div_req_o.start    = head_i.valid && div_need && !div_have_q &&
                              !div_rsp_i.busy && !div_rsp_i.done;
  assign div_req_o.dividend = div_a;
  assign div_req_o.divisor  = div_b;

  always_comb begin
    goto_t gt;
    mode_e m;
    logic  fail;
    logic  done;
    logic [2:0] code;
    gt      = '0;
    m       = mode_q;
    fail    = 1'b0;
    done    = 1'b0;
    code    = ERR_NOT_AVI;
    emit    = 1'b0;
    res_d   = '0;
    pos_d   = pos_q;
    hs_d    = hs;
    end_d   = end_q;
    pad_d   = pad_q;
    movi_d  = movi_q;
    lvl_d   = lvl_q;
    fc_d    = fc_q;
    sw_d    = sw_q;
    sh_d    = sh_q;
    sr_d    = sr_q;
    ff_d    = ff_q;
    mseen_d = mseen_q;
    id_d    = id_q;
    size_d  = size_q;
    ds_d    = ds_q;
    hst_d   = hst_q;
    skip_d  = skip_q;
    endc    = (p34 + 34'd1) + {2'b00, hs[63:32]};
    padded  = endc + {33'd0, hs[32]};
    li      = lvl_q - 1'b1;

    if (m == M_HALT) hs_d = hs_q;
    if (m == M_SKIP && p34 >= skip_q) begin
      m     = M_HDR;
      hst_d = p34;
    end

    unique case (m)
      M_SIG: begin
        if (pos_q == 32'd3) begin
          fc_d = hi;
        end else if (pos_q == 32'd11) begin
          if (fc_q != FCC_RIFF || hi != FCC_AVI) begin
            fail = 1'b1;
            code = ERR_NOT_AVI;
          end else begin
            gt = go_to(34'd12, lvl_d, end_d, pad_d);
            skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
          end
        end
      end
      M_HDR: begin
        if ({1'b0, p34} == {1'b0, hst_d} + 35'd7) begin
          id_d   = hs[31:0];
          size_d = hi;
          ds_d   = p34 + 34'd1;
          if (lvl_q == '0) begin
            if (endc > {2'b00, total_len_i}) begin
              m = M_IDLE;
            end else if (hs[31:0] == FCC_LIST && hi >= 32'd4) begin
              m = M_LTYPE;
            end else begin
              gt = go_to(padded, lvl_d, end_d, pad_d);
              skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
            end
          end else if (movi_q[li[IDX_W-1:0]]) begin
            if (endc > end_q[li[IDX_W-1:0]] || endc > {2'b00, total_len_i}) begin
              gt = go_to(end_q[li[IDX_W-1:0]] + {33'd0, pad_q[li[IDX_W-1:0]]},
                         li, end_d, pad_d);
              skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
            end else begin
              if (hs[31:0] == FCC_00DC || hs[31:0] == FCC_00DB) begin
                ff_d         = ff_q + 32'd1;
                emit         = 1'b1;
                res_d.kind   = KIND_FRAME;
                res_d.offset = pos_q + 32'd1;
                res_d.size   = hi;
              end
              gt = go_to(padded, lvl_d, end_d, pad_d);
              skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
            end
          end else if (endc > end_q[li[IDX_W-1:0]] || endc > {2'b00, total_len_i}) begin
            fail = 1'b1;
            code = ERR_MALFORMED;
          end else if ((hs[31:0] == FCC_AVIH && hi >= 32'd40) ||
                       (hs[31:0] == FCC_STRH && hi >= 32'd32) ||
                       (hs[31:0] == FCC_STRF && hi >= 32'd20)) begin
            m = M_BODY;
          end else if (hs[31:0] == FCC_LIST && hi >= 32'd4) begin
            m = M_LTYPE;
          end else begin
            gt = go_to(padded, lvl_d, end_d, pad_d);
            skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
          end
        end
      end
      M_LTYPE: begin
        if (p34 == ds_q + 34'd3) begin
          if (((lvl_q == '0) && (hi == FCC_HDRL || hi == FCC_MOVI)) ||
              ((lvl_q != '0) && hi == FCC_STRL &&
               lvl_q < NEST_W'(MAX_NEST))) begin
            end_d[lvl_q[IDX_W-1:0]]  = ds_q + {2'b00, size_q};
            pad_d[lvl_q[IDX_W-1:0]]  = size_q[0];
            movi_d[lvl_q[IDX_W-1:0]] = (lvl_q == '0) && hi == FCC_MOVI;
            if ((lvl_q == '0) && hi == FCC_MOVI) mseen_d = 1'b1;
            gt = go_to(ds_q + 34'd4, lvl_q + 1'b1, end_d, pad_d);
          end else begin
            gt = go_to(ds_q + {2'b00, size_q} + {33'd0, size_q[0]}, lvl_q, end_d, pad_d);
          end
          skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
        end
      end
      M_BODY: begin
        if (p34 >= ds_q) begin
          if (id_q == FCC_AVIH) begin
            if (off == 34'd3 && hi != '0) sr_d = rate_q1;
            else if (off == 34'd35) sw_d = hi;
            else if (off == 34'd39) begin sh_d = hi; done = 1'b1; end
          end else if (id_q == FCC_STRH) begin
            if (off == 34'd23) fc_d = hi;
            else if (off == 34'd27) begin
              if (fc_q != '0 && hi != '0) sr_d = rate_q1;
              done = 1'b1;
            end
          end else begin
            if (off == 34'd7) sw_d = hi;
            else if (off == 34'd11) sh_d = hi;
            else if (off == 34'd15) fc_d = hi;
            else if (off == 34'd19) begin
              if (fc_q[15:0] != 16'd1 || fc_q[31:16] != 16'd24 || hi != FCC_MJPG) begin
                fail = 1'b1;
                code = ERR_BAD_FMT;
              end else begin
                done = 1'b1;
              end
            end
          end
          if (done) begin
            gt = go_to(ds_q + {2'b00, size_q} + {33'd0, size_q[0]}, lvl_d, end_d, pad_d);
            skip_d = gt.tgt; lvl_d = gt.lvl; m = M_SKIP;
          end
        end
      end
      default: ;
    endcase

    if (fail) begin
      emit      = 1'b1;
      res_d     = '0;
      res_d.kind = KIND_ERROR;
      res_d.err = code;
      m         = M_HALT;
    end else if (m != M_HALT) begin
      pos_d = pos_q + 32'd1;
      if ({1'b0, pos_q} + 33'd1 >= {1'b0, total_len_i}) begin
        emit  = 1'b1;
        res_d = '0;
        if (m == M_SIG) begin
          res_d.kind = KIND_ERROR; res_d.err = ERR_NOT_AVI;
        end else if (!mseen_d) begin
          res_d.kind = KIND_ERROR; res_d.err = ERR_NO_MOVI;
        end else if (ff_d == '0) begin
          res_d.kind = KIND_ERROR; res_d.err = ERR_NO_FRAMES;
        end else if (sw_d == '0 || sh_d == '0) begin
          res_d.kind = KIND_ERROR; res_d.err = ERR_NO_SIZE;
        end else begin
          res_d.kind   = KIND_DONE;
          res_d.width  = sw_d;
          res_d.height = sh_d;
          res_d.rate   = sr_d;
          res_d.total  = ff_d;
        end
        m = M_HALT;
      end
    end
    mode_d = m;
  end

  assign out_valid_o = outv_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (go && emit) res_q <= res_d;
    if (div_rsp_i.done) div_quo_q <= div_rsp_i.quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= M_SIG;
      pos_q      <= '0;
      hs_q       <= '0;
      end_q      <= '0;
      pad_q      <= '0;
      movi_q     <= '0;
      lvl_q      <= '0;
      fc_q       <= '0;
      sw_q       <= '0;
      sh_q       <= '0;
      sr_q       <= '0;
      ff_q       <= '0;
      mseen_q    <= 1'b0;
      id_q       <= '0;
      size_q     <= '0;
      ds_q       <= '0;
      hst_q      <= '0;
      skip_q     <= '0;
      div_have_q <= 1'b0;
      outv_q     <= 1'b0;
    end else begin
      if (div_rsp_i.done) div_have_q <= 1'b1;
      if (outv_q && out_ready_i) outv_q <= 1'b0;
      if (go) begin
        mode_q     <= mode_d;
        pos_q      <= pos_d;
        hs_q       <= hs_d;
        end_q      <= end_d;
        pad_q      <= pad_d;
        movi_q     <= movi_d;
        lvl_q      <= lvl_d;
        fc_q       <= fc_d;
        sw_q       <= sw_d;
        sh_q       <= sh_d;
        sr_q       <= sr_d;
        ff_q       <= ff_d;
        mseen_q    <= mseen_d;
        id_q       <= id_d;
        size_q     <= size_d;
        ds_q       <= ds_d;
        hst_q      <= hst_d;
        skip_q     <= skip_d;
        div_have_q <= 1'b0;
        if (emit) outv_q <= 1'b1;
      end
    end
  end

endmodule

[design/riff_avi_demux_parser_unit.sv]
// Top level of the AVI container parser: byte queue, parser core, divider, length register.
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tdata[7:0] data_byte
//  m_axis   out  m_axis_tvalid/tready      tdata frame fields, tuser result_kind
//  cfg      in   cfg_valid_i/cfg_ready_o   cfg_data_i total_length
//
// One byte per cycle while the core is not stalled; a byte that sets the frame rate waits for
// the 32-step divider. After reset the parser waits for the RIFF signature, total_length is 1.
// A pending result stalls the core only when it has another to give; the four-beat byte
// queue keeps taking beats meanwhile. Bytes after the result that ends the file are dropped.
module riff_avi_demux_parser_unit import rad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] frame_offset, [63:32] frame_size, [95:64] frame_width, [127:96] frame_height,
  // [159:128] frame_rate, [191:160] frame_total, [194:192] error_code, rest zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]         m_axis_tuser,   // [1:0] result_kind
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);

  logic [31:0]  tl_q;
  rad_beat_t    head;
  logic         pop;
  rad_div_req_t div_req;
  rad_div_rsp_t div_rsp;
  rad_res_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tl_q <= 32'd1;
    else if (cfg_valid_i) tl_q <= cfg_data_i;
  end

  rad_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .head_o     (head),
    .pop_i      (pop)
  );

  rad_div u_div (
    .clk_i, .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  rad_back u_back (
    .clk_i, .rst_ni,
    .total_len_i (tl_q),
    .head_i      (head),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {5'd0, res.err, res.total, res.rate, res.height, res.width,
                         res.size, res.offset};

endmodule
